>>> src/mpps_pkg.sv
package mpps_pkg;

    localparam int COORD_W  = 24;
    localparam int DIFF_W   = 25;
    localparam int R2_W     = 48;
    localparam int ENERGY_W = 40;
    localparam int TAB_W    = 18;

    localparam logic [21:0] MORSE_D  = 22'd2402812;
    localparam logic [19:0] MORSE_A  = 20'd963379;
    localparam logic [14:0] MORSE_R0 = 15'd17367;
    localparam logic [16:0] LOG2E    = 17'd94548;
    localparam longint unsigned LN2_Q30 = 64'd744261118;

    localparam logic signed [ENERGY_W-1:0] SUM_MAX = {1'b0, {(ENERGY_W-1){1'b1}}};
    localparam logic signed [ENERGY_W-1:0] SUM_MIN = {1'b1, {(ENERGY_W-1){1'b0}}};

    typedef struct packed {
        logic            contrib;
        logic            last;
        logic [R2_W-1:0] r2;
    } job_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_MUL,
        F_PUSH
    } front_state_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_SQRT,
        B_XMUL,
        B_ZMUL,
        B_POS,
        B_TAB0,
        B_TAB1,
        B_INTERP,
        B_SHIFT,
        B_SQ,
        B_DM,
        B_ACC
    } back_state_t;

endpackage

>>> src/mpps_if.sv
interface mpps_in_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] point_x;
    logic signed [23:0] point_y;
    logic signed [23:0] point_z;
    logic signed [23:0] atom_x;
    logic signed [23:0] atom_y;
    logic signed [23:0] atom_z;
    logic               is_gold;
    logic               last_atom;

    modport source (
        output valid, point_x, point_y, point_z, atom_x, atom_y, atom_z, is_gold, last_atom,
        input  ready
    );
    modport sink (
        input  valid, point_x, point_y, point_z, atom_x, atom_y, atom_z, is_gold, last_atom,
        output ready
    );
endinterface

interface mpps_out_if;
    logic               valid;
    logic               ready;
    logic signed [39:0] energy;

    modport source (output valid, energy, input ready);
    modport sink (input valid, energy, output ready);
endinterface

>>> src/morse_potential_point_sum.sv
// The front captures an atom and then takes three squaring steps; the back then
// runs the bit-serial square root and the exponent sequence for a gold atom
// inside the cutoff and goes straight to accumulation for any other atom; the
// run's sum is registered onto the output. The back takes a new item only once
// it is through with the last one; the front overlaps with it.
// Reset clears the running sum, the queue and all handshake state at once.
module morse_potential_point_sum #(
    parameter int EXP_TABLE_DEPTH = 1024,
    parameter int COORD_FRAC_BITS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    mpps_in_if.sink    in_item,
    mpps_out_if.source out_item
);
    import mpps_pkg::*;

    job_t front_job;
    logic front_valid;
    logic front_ready;
    job_t back_job;
    logic back_valid;
    logic back_ready;

    mpps_front #(
        .COORD_FRAC_BITS(COORD_FRAC_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_item  (in_item),
        .job      (front_job),
        .job_valid(front_valid),
        .job_ready(front_ready)
    );

    mpps_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_job  (front_job),
        .wr_valid(front_valid),
        .wr_ready(front_ready),
        .rd_job  (back_job),
        .rd_valid(back_valid),
        .rd_ready(back_ready)
    );

    mpps_back #(
        .EXP_TABLE_DEPTH(EXP_TABLE_DEPTH),
        .COORD_FRAC_BITS(COORD_FRAC_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .job      (back_job),
        .job_valid(back_valid),
        .job_ready(back_ready),
        .out_item (out_item)
    );

endmodule

>>> src/mpps_front.sv
module mpps_front #(
    parameter int COORD_FRAC_BITS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    mpps_in_if.sink       in_item,
    output mpps_pkg::job_t job,
    output logic          job_valid,
    input  logic          job_ready
);
    import mpps_pkg::*;

    localparam logic [50:0] R2_LIM = 51'(1) << (2 * COORD_FRAC_BITS);

    front_state_t             state_reg, state_next;
    logic [1:0]               cnt_reg;
    logic signed [DIFF_W-1:0] d_reg [3];
    logic                     gold_reg;
    logic                     last_reg;
    logic [50:0]              acc_reg;
    logic signed [49:0]       sq;

    assign sq = d_reg[cnt_reg] * d_reg[cnt_reg];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (in_item.valid)
                begin
                    state_next = F_MUL;
                end
            end
            F_MUL:
            begin
                if (cnt_reg == 2'd2)
                begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (job_ready)
                begin
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_comb
    begin
        in_item.ready = (state_reg == F_IDLE);
        job_valid     = (state_reg == F_PUSH);
        job.contrib   = gold_reg && (acc_reg < R2_LIM);
        job.last      = last_reg;
        job.r2        = acc_reg[R2_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == F_IDLE && in_item.valid)
        begin
            d_reg[0] <= DIFF_W'(in_item.atom_x) - DIFF_W'(in_item.point_x);
            d_reg[1] <= DIFF_W'(in_item.atom_y) - DIFF_W'(in_item.point_y);
            d_reg[2] <= DIFF_W'(in_item.atom_z) - DIFF_W'(in_item.point_z);
            gold_reg <= in_item.is_gold;
            last_reg <= in_item.last_atom;
            acc_reg  <= '0;
            cnt_reg  <= '0;
        end
        else if (state_reg == F_MUL)
        begin
            acc_reg <= acc_reg + 51'($unsigned(sq));
            cnt_reg <= cnt_reg + 2'd1;
        end
    end

endmodule

>>> src/mpps_queue.sv
module mpps_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  mpps_pkg::job_t wr_job,
    input  logic           wr_valid,
    output logic           wr_ready,
    output mpps_pkg::job_t rd_job,
    output logic           rd_valid,
    input  logic           rd_ready
);
    import mpps_pkg::*;

    job_t       mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    logic       pop;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_job   = mem_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_job;
        end
    end

endmodule

>>> src/mpps_back.sv
module mpps_back #(
    parameter int EXP_TABLE_DEPTH = 1024,
    parameter int COORD_FRAC_BITS = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  mpps_pkg::job_t job,
    input  logic           job_valid,
    output logic           job_ready,
    mpps_out_if.source     out_item
);
    import mpps_pkg::*;

    localparam int F  = COORD_FRAC_BITS;
    localparam int RW = F + 3;
    localparam int SW = $clog2(F);
    localparam int TW = $clog2(EXP_TABLE_DEPTH + 1);

    typedef logic [TAB_W-1:0] tab_t [0:EXP_TABLE_DEPTH];

    function automatic longint unsigned udiv(input longint unsigned num,
                                             input longint unsigned den);
        longint unsigned q;
        longint unsigned r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--)
        begin
            r = {r[62:0], num[i]};
            if (r >= den)
            begin
                r    = r - den;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic tab_t build_tab();
        tab_t            t;
        longint unsigned y;
        longint unsigned term;
        longint unsigned sum;
        for (int k = 0; k <= EXP_TABLE_DEPTH; k++)
        begin
            y    = udiv(64'(k) * LN2_Q30, 64'(EXP_TABLE_DEPTH));
            term = 64'd1 << 30;
            sum  = term;
            for (int n = 1; n <= 24; n++)
            begin
                if (term != 0)
                begin
                    term = udiv((term * y) >> 30, 64'(n));
                    sum  = sum + term;
                end
            end
            t[k] = TAB_W'((sum + (64'd1 << 13)) >> 14);
        end
        return t;
    endfunction

    localparam tab_t EXP_TAB = build_tab();

    back_state_t                state_reg, state_next;
    logic [SW-1:0]              cnt_reg;
    logic [2*F-1:0]             v_reg;
    logic [RW-1:0]              rem_reg;
    logic [F-1:0]               root_reg;
    logic                       contrib_reg;
    logic                       last_reg;
    logic signed [23:0]         x_reg;
    logic signed [25:0]         z_reg;
    logic [TW-1:0]              idx_reg;
    logic [15:0]                fr_reg;
    logic [TAB_W-1:0]           rom_q_reg;
    logic [TAB_W-1:0]           lo_reg;
    logic [TAB_W:0]             mant_reg;
    logic signed [24:0]         m_reg;
    logic [32:0]                m2_reg;
    logic signed [33:0]         term_reg;
    logic signed [ENERGY_W-1:0] sum_reg;
    logic                       out_valid_reg;
    logic signed [ENERGY_W-1:0] out_energy_reg;

    logic [RW-1:0]              rem_sh;
    logic [RW-1:0]              trial;
    logic [15:0]                rq;
    logic signed [18:0]         dr;
    logic signed [39:0]         xp;
    logic signed [41:0]         zp;
    logic [32:0]                pos;
    logic [TAB_W-1:0]           diff;
    logic [33:0]                ip;
    logic signed [9:0]          nexp;
    logic [9:0]                 nneg;
    logic [39:0]                e;
    logic signed [49:0]         mm;
    logic signed [56:0]         tp;
    logic signed [41:0]         s;
    logic signed [ENERGY_W-1:0] sat;
    logic                       stall;

    assign rem_sh = {rem_reg[RW-3:0], v_reg[2*F-1 -: 2]};
    assign trial  = RW'({root_reg, 2'b01});

    generate
        if (F >= 16)
        begin : g_rq_trunc
            assign rq = 16'(root_reg >> (F - 16));
        end
        else
        begin : g_rq_shift
            assign rq = 16'(root_reg) << (16 - F);
        end
    endgenerate

    assign dr   = 19'sd17367 - $signed({3'b000, rq});
    assign xp   = $signed({1'b0, MORSE_A}) * dr;
    assign zp   = x_reg * $signed({1'b0, LOG2E});
    assign pos  = 33'(z_reg[15:0]) * 33'(EXP_TABLE_DEPTH);
    assign diff = (rom_q_reg >= lo_reg) ? (rom_q_reg - lo_reg) : '0;
    assign ip   = 34'(diff) * 34'(fr_reg);
    assign nexp = z_reg[25:16];
    assign nneg = 10'(-nexp);
    assign mm   = m_reg * m_reg;
    assign tp   = $signed({1'b0, MORSE_D}) * $signed({1'b0, m2_reg});

    always_comb
    begin
        if (!nexp[9])
        begin
            e = (nexp > 10'sd20) ? (40'(mant_reg) << 20) : (40'(mant_reg) << nexp);
        end
        else if (nneg >= 10'd40)
        begin
            e = '0;
        end
        else
        begin
            e = 40'(mant_reg) >> nneg;
        end
    end

    always_comb
    begin
        s = 42'(sum_reg) + (contrib_reg ? 42'(term_reg) : 42'sd0);
        if (s > 42'(SUM_MAX))
        begin
            sat = SUM_MAX;
        end
        else if (s < 42'(SUM_MIN))
        begin
            sat = SUM_MIN;
        end
        else
        begin
            sat = ENERGY_W'(s);
        end
    end

    assign stall = last_reg && out_valid_reg && !out_item.ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (job_valid)
                begin
                    state_next = job.contrib ? B_SQRT : B_ACC;
                end
            end
            B_SQRT:
            begin
                if (cnt_reg == SW'(F - 1))
                begin
                    state_next = B_XMUL;
                end
            end
            B_XMUL:   state_next = B_ZMUL;
            B_ZMUL:   state_next = B_POS;
            B_POS:    state_next = B_TAB0;
            B_TAB0:   state_next = B_TAB1;
            B_TAB1:   state_next = B_INTERP;
            B_INTERP: state_next = B_SHIFT;
            B_SHIFT:  state_next = B_SQ;
            B_SQ:     state_next = B_DM;
            B_DM:     state_next = B_ACC;
            B_ACC:
            begin
                if (!stall)
                begin
                    state_next = B_IDLE;
                end
            end
            default:  state_next = B_IDLE;
        endcase
    end

    always_comb
    begin
        job_ready       = (state_reg == B_IDLE);
        out_item.valid  = out_valid_reg;
        out_item.energy = out_energy_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == B_ACC && !stall && last_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_item.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == B_ACC && !stall)
            begin
                if (last_reg)
                begin
                    sum_reg <= '0;
                end
                else
                begin
                    sum_reg <= sat;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_IDLE:
            begin
                v_reg       <= job.r2[2*F-1:0];
                rem_reg     <= '0;
                root_reg    <= '0;
                cnt_reg     <= '0;
                contrib_reg <= job.contrib;
                last_reg    <= job.last;
            end
            B_SQRT:
            begin
                v_reg   <= v_reg << 2;
                cnt_reg <= cnt_reg + SW'(1);
                if (rem_sh >= trial)
                begin
                    rem_reg  <= rem_sh - trial;
                    root_reg <= {root_reg[F-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= rem_sh;
                    root_reg <= {root_reg[F-2:0], 1'b0};
                end
            end
            B_XMUL:   x_reg     <= 24'((xp + 40'sd32768) >>> 16);
            B_ZMUL:   z_reg     <= 26'(zp >>> 16);
            B_POS:
            begin
                idx_reg <= pos[16 +: TW];
                fr_reg  <= pos[15:0];
            end
            B_TAB0:   rom_q_reg <= EXP_TAB[idx_reg];
            B_TAB1:
            begin
                lo_reg    <= rom_q_reg;
                rom_q_reg <= EXP_TAB[idx_reg + TW'(1)];
            end
            B_INTERP: mant_reg  <= (TAB_W + 1)'(lo_reg) + (TAB_W + 1)'(ip >> 16);
            B_SHIFT:  m_reg     <= 25'(41'sd65536 - $signed({1'b0, e}));
            B_SQ:     m2_reg    <= 33'((mm + 50'sd32768) >>> 16);
            B_DM:
            begin
                term_reg <= 34'((tp - (57'sd2402812 <<< 16) + 57'sd8388608) >>> 24);
            end
            B_ACC:
            begin
                if (!stall && last_reg)
                begin
                    out_energy_reg <= sat;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

>>> test/tb_morse_potential_point_sum.sv
module tb_morse_potential_point_sum;
    import mpps_pkg::*;

    typedef struct {
        logic signed [23:0] px, py, pz, ax, ay, az;
        logic               gold;
        logic               last;
        logic               hold;
    } atom_item_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    mpps_in_if  in_bus();
    mpps_out_if out_bus();

    morse_potential_point_sum DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_item  (in_bus),
        .out_item (out_bus)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    atom_item_t                  pending_q[$];
    logic signed [ENERGY_W-1:0]  energy_q[$];
    longint                      exp_lut[0:1024];
    longint                      energy_acc = 0;
    int                          errors = 0;
    int                          sent = 0;
    int                          results_seen = 0;
    int                          in_cutoff = 0;
    int                          send_gap = 0;
    int                          recv_wait = 0;
    int                          quiet = 0;
    int                          stall_left = 0;
    bit                          calm_send = 0;
    bit                          calm_recv = 0;

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d, expected %0d", what, got, want);
        errors++;
    endtask

    function automatic longint rshift_round(input longint v, input int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint int_sqrt(input longint v);
        longint res;
        longint b;
        res = 0;
        b = longint'(1) << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic longint exp_q16(input longint x);
        longint z, n, f, pos, idx, fr, lo, hi, mant;
        z = (x * longint'(LOG2E)) >>> 16;
        n = z >>> 16;
        f = z & 64'hFFFF;
        pos = f * 1024;
        idx = pos >> 16;
        fr = pos & 64'hFFFF;
        if (idx >= 1024)
            idx = 1023;
        lo = exp_lut[idx];
        hi = exp_lut[idx + 1];
        mant = lo + ((((hi >= lo) ? hi - lo : 0) * fr) >> 16);
        if (n >= 0)
        begin
            if (n > 20)
                n = 20;
            return mant << n;
        end
        if (-n >= 40)
            return 0;
        return mant >> (-n);
    endfunction

    function automatic longint morse_energy(input longint r2);
        longint r, x, m, m2, t;
        r = int_sqrt(r2);
        x = rshift_round(longint'(MORSE_A) * (longint'(MORSE_R0) - r), 16);
        m = 65536 - exp_q16(x);
        m2 = rshift_round(m * m, 16);
        t = longint'(MORSE_D) * m2 - (longint'(MORSE_D) << 16);
        return rshift_round(t, 24);
    endfunction

    task automatic predict_atom(input atom_item_t it);
        longint dx, dy, dz, r2, s;
        dx = longint'(it.ax) - longint'(it.px);
        dy = longint'(it.ay) - longint'(it.py);
        dz = longint'(it.az) - longint'(it.pz);
        r2 = dx * dx + dy * dy + dz * dz;
        if (it.gold && r2 < (longint'(1) << 32))
        begin
            in_cutoff++;
            s = energy_acc + morse_energy(r2);
            if (s > longint'(SUM_MAX))
                s = longint'(SUM_MAX);
            if (s < longint'(SUM_MIN))
                s = longint'(SUM_MIN);
            energy_acc = s;
        end
        if (it.last)
        begin
            energy_q.insert(energy_q.size(), energy_acc[ENERGY_W-1:0]);
            energy_acc = 0;
        end
    endtask

    function automatic void build_lut();
        longint unsigned y, term, acc;
        for (int k = 0; k <= 1024; k++)
        begin
            y = (longint'(k) * LN2_Q30) / 1024;
            term = longint'(1) << 30;
            acc = term;
            for (int n = 1; n <= 24 && term != 0; n++)
            begin
                term = ((term * y) >> 30) / n;
                acc += term;
            end
            exp_lut[k] = (acc + (1 << 13)) >> 14;
        end
    endfunction

    function automatic int draw_gap(input bit calm);
        return calm ? 0 : $urandom_range(0, 9);
    endfunction

    task automatic add_atom(input logic signed [23:0] px, py, pz,
                            input longint ox, oy, oz, input logic gold, last, hold);
        atom_item_t it;
        it.px = px;
        it.py = py;
        it.pz = pz;
        it.ax = 24'(longint'(px) + ox);
        it.ay = 24'(longint'(py) + oy);
        it.az = 24'(longint'(pz) + oz);
        it.gold = gold;
        it.last = last;
        it.hold = hold;
        pending_q.insert(pending_q.size(), it);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_bus.valid <= 1'b0;
            in_bus.point_x <= '0;
            in_bus.point_y <= '0;
            in_bus.point_z <= '0;
            in_bus.atom_x <= '0;
            in_bus.atom_y <= '0;
            in_bus.atom_z <= '0;
            in_bus.is_gold <= 1'b0;
            in_bus.last_atom <= 1'b0;
        end
        else
        begin
            if (in_bus.valid && in_bus.ready)
            begin
                atom_item_t it;
                it.px = in_bus.point_x;
                it.py = in_bus.point_y;
                it.pz = in_bus.point_z;
                it.ax = in_bus.atom_x;
                it.ay = in_bus.atom_y;
                it.az = in_bus.atom_z;
                it.gold = in_bus.is_gold;
                it.last = in_bus.last_atom;
                predict_atom(it);
                sent++;
            end
            quiet <= (energy_q.size() == 0 && !in_bus.valid) ? quiet + 1 : 0;
            if (!in_bus.valid || in_bus.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    in_bus.valid <= 1'b0;
                end
                else if (pending_q.size() != 0 &&
                         (!pending_q[0].hold || (quiet > 60 && !in_bus.valid)))
                begin
                    atom_item_t it;
                    it = pending_q.pop_front();
                    in_bus.valid <= 1'b1;
                    in_bus.point_x <= it.px;
                    in_bus.point_y <= it.py;
                    in_bus.point_z <= it.pz;
                    in_bus.atom_x <= it.ax;
                    in_bus.atom_y <= it.ay;
                    in_bus.atom_z <= it.az;
                    in_bus.is_gold <= it.gold;
                    in_bus.last_atom <= it.last;
                    send_gap <= draw_gap(calm_send);
                end
                else
                    in_bus.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_bus.ready <= 1'b0;
            recv_wait <= 0;
        end
        else
        begin
            if (out_bus.valid && out_bus.ready)
            begin
                results_seen++;
                if (energy_q.size() == 0)
                    report("unexpected energy", longint'(out_bus.energy), 0);
                else
                begin
                    logic signed [ENERGY_W-1:0] want;
                    want = energy_q.pop_front();
                    if (out_bus.energy !== want)
                        report("energy", longint'(out_bus.energy), longint'(want));
                end
            end
            if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                out_bus.ready <= 1'b0;
            end
            else if (out_bus.valid && out_bus.ready)
            begin
                int w;
                w = draw_gap(calm_recv);
                recv_wait <= w;
                out_bus.ready <= (w == 0);
            end
            else if (recv_wait > 0)
            begin
                recv_wait <= recv_wait - 1;
                out_bus.ready <= (recv_wait == 1);
            end
            else
                out_bus.ready <= 1'b1;
        end
    end

    initial
    begin
        #2_000_000;
        $display("timeout: %0d items sent, %0d results", sent, results_seen);
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        logic signed [23:0] px, py, pz;
        int total;
        int run_len;
        int pick;
        longint ox, oy, oz;
        build_lut();

        add_atom(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 0, 0, 0, 1, 1, 0);
        add_atom(24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF, -24'sh7FFFFF, 0, 0, 1, 1, 0);
        add_atom(0, 0, 0, 65536, 0, 0, 1, 0, 0);
        add_atom(0, 0, 0, 65535, 0, 0, 1, 0, 0);
        add_atom(0, 0, 0, 0, -65535, 0, 1, 0, 0);
        add_atom(0, 0, 0, 0, 0, 17367, 1, 1, 0);
        add_atom(24'sh123456, -24'sh54321, 24'sh0ABCDE, 1000, -2000, 3000, 0, 1, 0);
        add_atom(24'sh800000, 24'sh800000, 24'sh800000, 0, 0, 0, 0, 0, 0);
        add_atom(24'sh800000, 24'sh800000, 24'sh800000, 1, 1, 1, 1, 1, 0);
        add_atom(-24'sh10000, 24'sh5555, -24'sh2AAAA, 37837, 37837, 37836, 1, 0, 0);
        add_atom(-24'sh10000, 24'sh5555, -24'sh2AAAA, 20000, -10000, 5000, 1, 0, 0);
        add_atom(-24'sh10000, 24'sh5555, -24'sh2AAAA, 60000, 0, 0, 1, 1, 0);
        add_atom(24'sh0, 24'sh0, 24'sh0, 8, 0, 0, 1, 1, 1);

        total = pending_q.size();
        while (total < 610)
        begin
            pick = $urandom_range(0, 99);
            px = (pick < 50) ? 24'($urandom) : 24'($urandom_range(0, 131071) - 65536);
            py = 24'($urandom);
            pz = (pick < 30) ? 24'($urandom) : 24'($urandom_range(0, 4095));
            run_len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 12);
            for (int i = 0; i < run_len; i++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 75)
                begin
                    ox = longint'($urandom_range(0, 75000)) - 37500;
                    oy = longint'($urandom_range(0, 75000)) - 37500;
                    oz = longint'($urandom_range(0, 75000)) - 37500;
                end
                else if (pick < 88)
                begin
                    ox = longint'($urandom_range(65530, 65540)) * (($urandom & 1) ? 1 : -1);
                    oy = longint'($urandom_range(0, 3));
                    oz = 0;
                end
                else
                begin
                    ox = longint'($signed(24'($urandom)));
                    oy = longint'($signed(24'($urandom)));
                    oz = longint'($signed(24'($urandom)));
                end
                add_atom(px, py, pz, ox, oy, oz, ($urandom_range(0, 99) < 85),
                         (i == run_len - 1), (total == 300));
                total++;
            end
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        wait (sent >= 40);
        @(posedge clk);
        stall_left <= 400;
        wait (sent >= 150);
        calm_send = 1;
        calm_recv = 1;
        wait (sent >= 260);
        calm_send = 0;
        calm_recv = 0;

        wait (pending_q.size() == 0 && !in_bus.valid);
        wait (energy_q.size() == 0);
        repeat (80) @(posedge clk);
        $display("%0d atoms sent, %0d inside the cutoff, %0d run sums compared", sent,
                 in_cutoff, results_seen);
        if (errors == 0 && energy_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
